@@ sv/phe_pkg.sv @@
// ----------------------------------------------------------------------------
// phe_pkg : shared types and constants of the polar hand endpoint
// widths of the request and result fields, angle constants of the sine
// approximation, register indexes and the work item passed front to back
// ----------------------------------------------------------------------------
package phe_pkg;

    // field widths
    localparam int ANG_W      = 10;
    localparam int LEN_W      = 8;
    localparam int COORD_W    = 10;
    localparam int OUT_W      = 12;
    localparam int DEG_W      = 8;
    localparam int PROD_W     = 14;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // work queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // angle constants
    localparam logic [ANG_W-1:0] DEG_FULL      = 10'd360;
    localparam logic [ANG_W-1:0] DEG_TWO_TURNS = 10'd720;
    localparam logic [ANG_W-1:0] DEG_QUARTER   = 10'd90;
    localparam logic [ANG_W-1:0] ANG_HALF      = 10'd180;
    localparam logic [DEG_W-1:0] DEG_HALF      = 8'd180;
    localparam logic [DIV_W-1:0] BHASKARA_K    = 16'd40500;

    // configuration
    localparam logic [COORD_W-1:0]   CENTER_RESET = 10'd120;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_center;

    // classified request: folded products and signs of sine and cosine
    typedef struct packed {
        logic [PROD_W-1:0] prod_s;
        logic              neg_s;
        logic [PROD_W-1:0] prod_c;
        logic              neg_c;
        logic [LEN_W-1:0]  len;
    } t_work;

endpackage

@@ sv/phe_req_if.sv @@
// ----------------------------------------------------------------------------
// phe_req_if : request channel of the polar hand endpoint
// valid/ready handshake carrying an angle and a ray length
// ----------------------------------------------------------------------------
interface phe_req_if import phe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ANG_W-1:0] angle_deg;
    logic [LEN_W-1:0] ray_length;

    modport source (output valid, output angle_deg, output ray_length, input ready);
    modport sink   (input valid, input angle_deg, input ray_length, output ready);
endinterface

@@ sv/phe_res_if.sv @@
// ----------------------------------------------------------------------------
// phe_res_if : result channel of the polar hand endpoint
// valid/ready handshake carrying the endpoint and the sine and cosine values
// ----------------------------------------------------------------------------
interface phe_res_if import phe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] end_x;
    logic signed [OUT_W-1:0] end_y;
    logic signed [OUT_W-1:0] sine_value;
    logic signed [OUT_W-1:0] cosine_value;

    modport source (output valid, output end_x, output end_y, output sine_value,
                    output cosine_value, input ready);
    modport sink   (input valid, input end_x, input end_y, input sine_value,
                    input cosine_value, output ready);
endinterface

@@ sv/polar_hand_endpoint.sv @@
// ----------------------------------------------------------------------------
// polar_hand_endpoint : endpoint of a clock hand from angle and length
// bhaskara sine/cosine approximation and pixel endpoint around a set center
// ----------------------------------------------------------------------------
// Takes one request per cycle unless result back-pressure stalls it (angle in
// whole degrees, 0 up and clockwise, any 10-bit value reduced mod 360, plus a
// ray length) and returns one result per request with the endpoint
// x = cx + len*sin/2^SCALE_BITS and y = cy - len*cos/2^SCALE_BITS, all
// divisions truncating toward zero, along with the scaled sine and cosine
// themselves (12-bit, wrapping above full scale once SCALE_BITS exceeds 10).
// A request passes through two front stages, the work queue, and in the back
// one operand stage, SCALE_BITS + 1 divider stages (one quotient bit each), a
// multiply stage and the result register. Only the divider depth varies with
// SCALE_BITS. A four-entry queue sits between intake and the divider pipeline,
// so requests keep being taken while a finished result waits on the sink,
// until the queue fills. The center registers are written through the plain
// write port and must only change while idle.
// ----------------------------------------------------------------------------
module polar_hand_endpoint import phe_pkg::*; #(
    parameter int SCALE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    phe_req_if.sink               i_req,
    phe_res_if.source             o_res
);

    // ray origin; the user must write it only while no request is in flight, the block does not enforce this
    t_center r_center;

    // front to queue
    logic  w_push;
    t_work w_work;
    logic  w_push_ready;

    // queue to back
    logic  w_q_valid;
    t_work w_q_data;
    logic  w_pop;

    // register write port, unknown indexes fall to the default arm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center.x <= CENTER_RESET;
            r_center.y <= CENTER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center.x <= i_cfg_data;
                CFG_CENTER_Y: r_center.y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // intake: angle reduction, folding and bhaskara products
    phe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push       (w_push),
        .o_work       (w_work),
        .i_push_ready (w_push_ready)
    );

    // decoupling queue
    phe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_data       (w_work),
        .o_push_ready (w_push_ready),
        .o_valid      (w_q_valid),
        .o_data       (w_q_data),
        .i_pop        (w_pop)
    );

    // division, scaling and endpoint in the result register
    phe_back #(.SCALE_BITS(SCALE_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_work   (w_q_data),
        .o_pop    (w_pop),
        .i_center (r_center),
        .o_res    (o_res)
    );

endmodule

@@ sv/phe_front.sv @@
// ----------------------------------------------------------------------------
// phe_front : request intake and classification
// reduces the angle mod 360, folds sine and cosine angles into 0..180 and
// forms the bhaskara product d*(180-d) for both, two register stages
// ----------------------------------------------------------------------------
module phe_front import phe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    phe_req_if.sink i_req,
    output logic   o_push,
    output t_work  o_work,
    input  logic   i_push_ready
);

    // fold result: sign in the top bit, folded angle below
    function automatic logic [DEG_W:0] fold_deg(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] t;
        t = a - ANG_HALF;
        if (a > ANG_HALF) begin
            return {1'b1, t[DEG_W-1:0]};
        end
        return {1'b0, a[DEG_W-1:0]};
    endfunction

    logic             r_f1_vld;
    logic [DEG_W-1:0] r_f1_ds;
    logic             r_f1_negs;
    logic [DEG_W-1:0] r_f1_dc;
    logic             r_f1_negc;
    logic [LEN_W-1:0] r_f1_len;
    logic             r_f2_vld;
    t_work            r_f2_work;

    logic             w_en1;
    logic             w_en2;
    logic [ANG_W-1:0] n_ang;
    logic [ANG_W-1:0] n_ang_sum;
    logic [ANG_W-1:0] n_ang_c;
    logic [DEG_W:0]   n_fold_s;
    logic [DEG_W:0]   n_fold_c;
    logic [DEG_W-1:0] n_comp_s;
    logic [DEG_W-1:0] n_comp_c;
    logic [2*DEG_W-1:0] n_prod_s;
    logic [2*DEG_W-1:0] n_prod_c;

    assign w_en2       = !r_f2_vld || i_push_ready;
    assign w_en1       = !r_f1_vld || w_en2;
    assign i_req.ready = w_en1;
    assign o_push      = r_f2_vld && i_push_ready;
    assign o_work      = r_f2_work;

    always_comb begin
        if (i_req.angle_deg >= DEG_TWO_TURNS) begin
            n_ang = i_req.angle_deg - DEG_TWO_TURNS;
        end else if (i_req.angle_deg >= DEG_FULL) begin
            n_ang = i_req.angle_deg - DEG_FULL;
        end else begin
            n_ang = i_req.angle_deg;
        end
        n_ang_sum = n_ang + DEG_QUARTER;
        n_ang_c   = (n_ang_sum >= DEG_FULL) ? (n_ang_sum - DEG_FULL) : n_ang_sum;
        n_fold_s  = fold_deg(n_ang);
        n_fold_c  = fold_deg(n_ang_c);
    end

    always_comb begin
        n_comp_s = DEG_HALF - r_f1_ds;
        n_comp_c = DEG_HALF - r_f1_dc;
        n_prod_s = r_f1_ds * n_comp_s;
        n_prod_c = r_f1_dc * n_comp_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r_f1_vld <= i_req.valid;
            end
            if (w_en2) begin
                r_f2_vld <= r_f1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_f1_ds   <= n_fold_s[DEG_W-1:0];
            r_f1_negs <= n_fold_s[DEG_W];
            r_f1_dc   <= n_fold_c[DEG_W-1:0];
            r_f1_negc <= n_fold_c[DEG_W];
            r_f1_len  <= i_req.ray_length;
        end
        if (w_en2) begin
            r_f2_work.prod_s <= n_prod_s[PROD_W-1:0];
            r_f2_work.neg_s  <= r_f1_negs;
            r_f2_work.prod_c <= n_prod_c[PROD_W-1:0];
            r_f2_work.neg_c  <= r_f1_negc;
            r_f2_work.len    <= r_f1_len;
        end
    end

endmodule

@@ sv/phe_queue.sv @@
// ----------------------------------------------------------------------------
// phe_queue : work queue between front and back
// small register fifo so intake and the divider pipeline stall on their own
// ----------------------------------------------------------------------------
module phe_queue import phe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_push_ready,
    output logic  o_valid,
    output t_work o_data,
    input  logic  i_pop
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_data       = r_mem[r_rd];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == QCNT_W'($past(r_cnt) + 1'b1)))
        else $error("queue count missed a push");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == QCNT_W'($past(r_cnt) - 1'b1)))
        else $error("queue count missed a pop");
`endif

endmodule

@@ sv/phe_div.sv @@
// ----------------------------------------------------------------------------
// phe_div : pipelined restoring divider
// one quotient bit per stage of num*2^(QW-1)/den, valid for num <= den
// ----------------------------------------------------------------------------
module phe_div import phe_pkg::*; #(
    parameter int QW = 11
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic [QW-1:0]    o_quo
);

    logic [DIV_W-1:0] r_rem [QW];
    logic [DIV_W-1:0] r_den [QW];
    logic [QW-1:0]    r_quo [QW];
    logic [DIV_W-1:0] n_rem [QW];
    logic [DIV_W-1:0] n_den [QW];
    logic [QW-1:0]    n_quo [QW];

    always_comb begin
        logic [DIV_W:0] t;
        // leading bit: num never exceeds den, so it is num >= den
        n_den[0] = i_den;
        if (i_num >= i_den) begin
            n_rem[0] = i_num - i_den;
            n_quo[0] = QW'(1);
        end else begin
            n_rem[0] = i_num;
            n_quo[0] = '0;
        end
        for (int k = 1; k < QW; k++) begin
            t        = {r_rem[k-1], 1'b0};
            n_den[k] = r_den[k-1];
            if (t >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = DIV_W'(t - {1'b0, r_den[k-1]});
                n_quo[k] = {r_quo[k-1][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DIV_W-1:0];
                n_quo[k] = {r_quo[k-1][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

@@ sv/phe_back.sv @@
// ----------------------------------------------------------------------------
// phe_back : sine, cosine and endpoint evaluation
// forms numerator and denominator, divides in two lockstep pipelines,
// scales by the ray length and adds the center into the result register
// ----------------------------------------------------------------------------
module phe_back import phe_pkg::*; #(
    parameter int SCALE_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_work     i_work,
    output logic      o_pop,
    input  t_center   i_center,
    phe_res_if.source o_res
);

    localparam int QW = SCALE_BITS + 1;
    localparam int PW = LEN_W + QW;
    localparam logic [QW-1:0] ONE_SCALED = QW'(1) << SCALE_BITS;

    logic                    w_adv;
    logic [QW:0]             r_vld;
    logic [LEN_W-1:0]        r_len  [QW+1];
    logic                    r_negs [QW+1];
    logic                    r_negc [QW+1];
    logic [DIV_W-1:0]        r_num_s;
    logic [DIV_W-1:0]        r_den_s;
    logic [DIV_W-1:0]        r_num_c;
    logic [DIV_W-1:0]        r_den_c;
    logic [QW-1:0]           w_quo_s;
    logic [QW-1:0]           w_quo_c;
    logic                    r_mul_vld;
    logic [QW-1:0]           r_mag_s;
    logic [QW-1:0]           r_mag_c;
    logic [PW-1:0]           r_prod_s;
    logic [PW-1:0]           r_prod_c;
    logic                    r_mneg_s;
    logic                    r_mneg_c;
    logic                    r_out_vld;
    logic signed [OUT_W-1:0] r_end_x;
    logic signed [OUT_W-1:0] r_end_y;
    logic signed [OUT_W-1:0] r_sine;
    logic signed [OUT_W-1:0] r_cosine;
    logic [OUT_W-1:0]        n_off_s;
    logic [OUT_W-1:0]        n_off_c;
    logic [DIV_W-1:0]        n_sig_s;
    logic [DIV_W-1:0]        n_sig_c;
    logic [OUT_W-1:0]        n_end_x;
    logic [OUT_W-1:0]        n_end_y;

    // whole pipeline moves together unless the result register is held
    assign w_adv = !r_out_vld || o_res.ready;
    assign o_pop = w_adv && i_valid;

    phe_div #(.QW(QW)) u_div_s (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_num_s),
        .i_den (r_den_s),
        .o_quo (w_quo_s)
    );

    phe_div #(.QW(QW)) u_div_c (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_num_c),
        .i_den (r_den_c),
        .o_quo (w_quo_c)
    );

    always_comb begin
        n_off_s = OUT_W'(r_prod_s[SCALE_BITS +: LEN_W]);
        n_off_c = OUT_W'(r_prod_c[SCALE_BITS +: LEN_W]);
        n_end_x = OUT_W'(i_center.x) + (r_mneg_s ? (~n_off_s + 1'b1) : n_off_s);
        n_end_y = OUT_W'(i_center.y) - (r_mneg_c ? (~n_off_c + 1'b1) : n_off_c);
        n_sig_s = r_mneg_s ? (~DIV_W'(r_mag_s) + 1'b1) : DIV_W'(r_mag_s);
        n_sig_c = r_mneg_c ? (~DIV_W'(r_mag_c) + 1'b1) : DIV_W'(r_mag_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_mul_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[QW-1:0], i_valid};
            r_mul_vld <= r_vld[QW];
            r_out_vld <= r_mul_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // numerator 4*p, denominator 40500-p
            r_num_s   <= {i_work.prod_s, 2'b00};
            r_den_s   <= BHASKARA_K - DIV_W'(i_work.prod_s);
            r_num_c   <= {i_work.prod_c, 2'b00};
            r_den_c   <= BHASKARA_K - DIV_W'(i_work.prod_c);
            r_len[0]  <= i_work.len;
            r_negs[0] <= i_work.neg_s;
            r_negc[0] <= i_work.neg_c;
            for (int k = 1; k <= QW; k++) begin
                r_len[k]  <= r_len[k-1];
                r_negs[k] <= r_negs[k-1];
                r_negc[k] <= r_negc[k-1];
            end
            r_mag_s  <= w_quo_s;
            r_mag_c  <= w_quo_c;
            r_prod_s <= r_len[QW] * w_quo_s;
            r_prod_c <= r_len[QW] * w_quo_c;
            r_mneg_s <= r_negs[QW];
            r_mneg_c <= r_negc[QW];
            r_end_x  <= n_end_x;
            r_end_y  <= n_end_y;
            r_sine   <= n_sig_s[OUT_W-1:0];
            r_cosine <= n_sig_c[OUT_W-1:0];
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.end_x        = r_end_x;
    assign o_res.end_y        = r_end_y;
    assign o_res.sine_value   = r_sine;
    assign o_res.cosine_value = r_cosine;

`ifndef SYNTHESIS
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW] |-> ((w_quo_s <= ONE_SCALED) && (w_quo_c <= ONE_SCALED)))
        else $error("divider quotient above full scale");

    a_pop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0])
        else $error("popped work did not enter the pipeline");
`endif

endmodule

@@ tb/phe_endpoint_checker.sv @@
// ----------------------------------------------------------------------------
// phe_endpoint_checker : result checker of the polar hand endpoint
// mirrors the center registers from the write port, predicts the endpoint,
// sine and cosine of every accepted request and compares each accepted
// result, in order, against the oldest prediction
// ----------------------------------------------------------------------------
module phe_endpoint_checker import phe_pkg::*; #(
    parameter int SCALE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    phe_req_if                    i_req,
    phe_res_if                    i_res,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    typedef struct packed {
        logic signed [OUT_W-1:0] end_x;
        logic signed [OUT_W-1:0] end_y;
        logic signed [OUT_W-1:0] sine_value;
        logic signed [OUT_W-1:0] cosine_value;
    } t_endpoint;

    t_center   center;
    t_endpoint endpoint_q [$];
    int        fail_count = 0;
    int        mismatch_count = 0;

    // bhaskara sine of a reduced angle, scaled by 2^SCALE_BITS
    function automatic int bhaskara_sine(input int deg);
        int     d;
        bit     negate;
        int     prod;
        longint mag;
        d      = deg % int'(DEG_FULL);
        negate = 1'b0;
        if (d > int'(ANG_HALF)) begin
            d      = d - int'(ANG_HALF);
            negate = 1'b1;
        end
        prod = d * (int'(ANG_HALF) - d);
        mag  = (longint'(4 * prod) << SCALE_BITS) / longint'(int'(BHASKARA_K) - prod);
        return negate ? -int'(mag) : int'(mag);
    endfunction

    // length times a scaled value, truncated toward zero
    function automatic int scale_by_length(input int len, input int s);
        int mag;
        int q;
        mag = (s < 0) ? -s : s;
        q   = (len * mag) >>> SCALE_BITS;
        return (s < 0) ? -q : q;
    endfunction

    function automatic t_endpoint predict_endpoint(input logic [ANG_W-1:0] angle,
                                                   input logic [LEN_W-1:0] len,
                                                   input t_center          org);
        t_endpoint e;
        int        ang;
        int        s;
        int        c;
        int        ex;
        int        ey;
        ang = int'(angle) % int'(DEG_FULL);
        s   = bhaskara_sine(ang);
        c   = bhaskara_sine((ang + int'(DEG_QUARTER)) % int'(DEG_FULL));
        ex  = int'(org.x) + scale_by_length(int'(len), s);
        ey  = int'(org.y) - scale_by_length(int'(len), c);
        e.end_x        = ex[OUT_W-1:0];
        e.end_y        = ey[OUT_W-1:0];
        e.sine_value   = s[OUT_W-1:0];
        e.cosine_value = c[OUT_W-1:0];
        return e;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_endpoint want;
        t_endpoint got;
        if (!i_rst_n) begin
            center.x = CENTER_RESET;
            center.y = CENTER_RESET;
            endpoint_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CENTER_X: center.x = i_cfg_data;
                    CFG_CENTER_Y: center.y = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                endpoint_q.push_back(predict_endpoint(i_req.angle_deg, i_req.ray_length,
                                                      center));
            if (i_res.valid && i_res.ready) begin
                got.end_x        = i_res.end_x;
                got.end_y        = i_res.end_y;
                got.sine_value   = i_res.sine_value;
                got.cosine_value = i_res.cosine_value;
                if (endpoint_q.size() == 0) begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("unexpected result x=%0d y=%0d sin=%0d cos=%0d",
                                 got.end_x, got.end_y, got.sine_value, got.cosine_value);
                    mismatch_count++;
                end else begin
                    want = endpoint_q.pop_front();
                    if (got.end_x !== want.end_x || got.end_y !== want.end_y ||
                        got.sine_value !== want.sine_value ||
                        got.cosine_value !== want.cosine_value) begin
                        fail_count++;
                        if (mismatch_count < 10)
                            $display("mismatch: expected x=%0d y=%0d sin=%0d cos=%0d, %s",
                                     want.end_x, want.end_y, want.sine_value,
                                     want.cosine_value,
                                     $sformatf("got x=%0d y=%0d sin=%0d cos=%0d",
                                               got.end_x, got.end_y, got.sine_value,
                                               got.cosine_value));
                        mismatch_count++;
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= endpoint_q.size();
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb : testbench of the polar hand endpoint
// drives directed and random angle/length requests over several center
// settings with random idling on both channels; the checker beside the
// block predicts and compares every result
// ----------------------------------------------------------------------------
module tb import phe_pkg::*;;

    localparam int SCALE_BITS = 10;
    // settle wait used after draining, in clock cycles
    localparam int LATENCY    = SCALE_BITS + 7;
    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 800000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    phe_req_if req_ch ();
    phe_res_if res_ch ();

    int fail_count;
    int outstanding;
    int cycle_count;
    bit steady;

    // directed requests: quadrant edges, the unfolded half turn, wrap past
    // one and two turns, the top of the angle field and both length extremes
    int unsigned dir_angle [25] = '{0, 90, 180, 270, 359, 360, 450, 540, 630, 719,
                                    720, 1023, 179, 181, 1, 89, 91, 269, 271, 45,
                                    135, 225, 315, 900, 1000};
    int unsigned dir_len   [25] = '{255, 255, 255, 255, 255, 0, 255, 1, 128, 255,
                                    200, 255, 255, 255, 255, 17, 255, 254, 127, 255,
                                    64, 3, 255, 99, 0};

    polar_hand_endpoint #(
        .SCALE_BITS (SCALE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    phe_endpoint_checker #(
        .SCALE_BITS (SCALE_BITS)
    ) endpoint_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // clock, period of ten
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: the run is cut off here if the block hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("polar_hand_endpoint test failed");
        $finish;
    end

    // idle length: mostly none or short, now and then long, none at all in
    // a steady phase
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure, changed at the falling edge only
    initial begin : res_stall
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left = idle_cycles();
            end
        end
    end

    // one request; entered and left at a falling edge, valid stays high
    // afterwards so a back-to-back request keeps it up without a dip
    task automatic send_request(input int unsigned angle, input int unsigned len);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.angle_deg  <= angle[ANG_W-1:0];
        req_ch.ray_length <= len[LEN_W-1:0];
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random request: mostly uniform, the rest close to a quadrant edge or
    // at the length extremes
    task automatic send_random_request();
        int unsigned angle;
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            angle = $urandom_range(0, 1023);
        else
            angle = 90 * $urandom_range(0, 11) + $urandom_range(0, 2);
        pick = $urandom_range(0, 3);
        case (pick)
            0:       len = 255;
            1:       len = $urandom_range(0, 3);
            default: len = $urandom_range(0, 255);
        endcase
        send_request(angle, len);
    endtask

    // wait until every predicted result has come back, then let the pipe settle
    task automatic wait_drained();
        while (outstanding != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // both center registers, one write per cycle, only while idle
    task automatic write_center(input int unsigned cx, input int unsigned cy);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CENTER_X;
        i_cfg_data  <= cx[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_CENTER_Y;
        i_cfg_data  <= cy[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // main sequence
    initial begin : stimulus
        int unsigned cx;
        int unsigned cy;
        // every input known from time zero
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_CENTER_X;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.angle_deg  = '0;
        req_ch.ray_length = '0;
        steady            = 1'b0;

        // synchronous reset held, then released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase at the reset center: directed requests, then random
        foreach (dir_angle[k])
            send_request(dir_angle[k], dir_len[k]);
        repeat (160) send_random_request();
        req_ch.valid <= 1'b0;

        // further phases at the corners of the center range and at random
        for (int p = 1; p <= 6; p++) begin
            wait_drained();
            case (p)
                1:       begin cx = 0;    cy = 0;    end
                2:       begin cx = 1023; cy = 1023; end
                3:       begin cx = 0;    cy = 1023; end
                4:       begin cx = 1023; cy = 0;    end
                default: begin
                    cx = $urandom_range(0, 1023);
                    cy = $urandom_range(0, 1023);
                end
            endcase
            write_center(cx, cy);
            steady = (p == 1) || ($urandom_range(0, 4) == 0);
            repeat (190) send_random_request();
            req_ch.valid <= 1'b0;
        end

        // drain, then a quiet tail to catch stray results
        steady = 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("polar_hand_endpoint test passed");
        end else begin
            $display("polar_hand_endpoint test failed");
        end
        $finish;
    end

endmodule

@@ polar_hand_endpoint.f @@
sv/phe_pkg.sv
sv/phe_req_if.sv
sv/phe_res_if.sv
sv/phe_front.sv
sv/phe_queue.sv
sv/phe_div.sv
sv/phe_back.sv
sv/polar_hand_endpoint.sv
tb/phe_endpoint_checker.sv
tb/tb.sv
